FILE: rtl/tvp_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner package
// Widths, phase and register codes, and the structs that travel between the
// pipeline stages and the root-extraction cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tvp_pkg;

  // Field widths.
  localparam int DIST_W    = 16;
  localparam int SPEED_W   = 16;
  localparam int RATE_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PHASE_W   = 3;

  // Root datapath: a 32-bit radicand gives a 16-bit root, one bit per cell.
  localparam int ROOT_W  = 16;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 1;
  localparam int DSUM_W  = DIST_W + 1;
  localparam int PROD_W  = RATE_W + DSUM_W;

  // Decode, product, radicand, one stage per root bit, output register.
  localparam int PIPE_DEPTH = ROOT_W + 4;

  // Profile phase codes as seen on the result channel.
  typedef enum logic [PHASE_W-1:0] {
    PH_LOW      = 3'd0,
    PH_SHORT    = 3'd1,
    PH_ACCEL    = 3'd2,
    PH_CRUISE   = 3'd3,
    PH_DECEL    = 3'd4,
    PH_ABNORMAL = 3'd5
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SPEED  = 3'd0,
    CFG_LOW_SPEED  = 3'd1,
    CFG_LOW_MODE   = 3'd2,
    CFG_RAMP_UP    = 3'd3,
    CFG_RAMP_DOWN  = 3'd4,
    CFG_ACCEL_RATE = 3'd5,
    CFG_DECEL_RATE = 3'd6
  } cfg_idx_t;

  // Current register settings.
  typedef struct packed {
    logic [SPEED_W-1:0] max_speed;
    logic [SPEED_W-1:0] low_speed;
    logic               low_mode;
    logic [DIST_W-1:0]  ramp_up;
    logic [DIST_W-1:0]  ramp_down;
    logic [RATE_W-1:0]  accel_rate;
    logic [RATE_W-1:0]  decel_rate;
  } tvp_cfg_t;

  // Result selection carried alongside the arithmetic.
  typedef struct packed {
    phase_t             phase;
    logic               use_root;
    logic [SPEED_W-1:0] speed;
  } tvp_side_t;

  // Output of the decode stage.
  typedef struct packed {
    tvp_side_t          side;
    logic [RATE_W-1:0]  rate;
    logic [DSUM_W-1:0]  ramp_dist;
  } tvp_dec_t;

  // Word handed from one root cell to the next.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    tvp_side_t         side;
  } tvp_root_t;

endpackage

`default_nettype wire

FILE: rtl/tvp_ifs.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner channel interfaces
// Valid/ready channels for the distance items and the speed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvp_in_if;
  logic                       valid;
  logic                       ready;
  logic [tvp_pkg::DIST_W-1:0] remaining_distance;
  logic [tvp_pkg::DIST_W-1:0] path_length;

  modport source (output valid, output remaining_distance, output path_length,
                  input ready);
  modport sink   (input valid, input remaining_distance, input path_length,
                  output ready);
endinterface

interface tvp_out_if;
  logic                        valid;
  logic                        ready;
  logic [tvp_pkg::SPEED_W-1:0] target_speed;
  logic [tvp_pkg::PHASE_W-1:0] profile_phase;

  modport source (output valid, output target_speed, output profile_phase,
                  input ready);
  modport sink   (input valid, input target_speed, input profile_phase,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/trapezoid_velocity_planner_top.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner
// Target speed from a trapezoidal profile, with a pipelined integer root.
//
//   Channel  Direction  Contents
//   in_ch    sink       remaining_distance, path_length (valid/ready)
//   out_ch   source     target_speed, profile_phase (valid/ready)
//   cfg_*    write      register index and data, no read-back
//
// One item per cycle sustained while out_ch takes its results; each result
// is offered once its input has passed 20 registers: decode, product,
// radicand, 16 root cells, output register.
// The root cells, one result bit each, set the latency.
// Reset clears all stage valid flags and loads the register defaults.
// A full stage holds while its successor cannot take it; empty stages close
// up, so inputs keep transferring while a result waits until all 20 are full.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_velocity_planner_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tvp_in_if.sink                             in_ch,
  tvp_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tvp_pkg::CFG_W-1:0]     cfg_wdata
);

  tvp_pkg::tvp_cfg_t  cfg_r;
  logic               dec_valid;
  logic               dec_ready;
  tvp_pkg::tvp_dec_t  dec_data;
  logic               out_vld_r;
  logic               out_stage_ready;
  logic [tvp_pkg::SPEED_W-1:0] speed_r;
  tvp_pkg::phase_t    phase_r;

  logic               cell_valid [tvp_pkg::ROOT_W+1];
  logic               cell_ready [tvp_pkg::ROOT_W+1];
  tvp_pkg::tvp_root_t cell_data  [tvp_pkg::ROOT_W+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed  <= 16'd480;
      cfg_r.low_speed  <= 16'd200;
      cfg_r.low_mode   <= 1'b0;
      cfg_r.ramp_up    <= 16'd150;
      cfg_r.ramp_down  <= 16'd150;
      cfg_r.accel_rate <= 16'd768;
      cfg_r.decel_rate <= 16'd768;
    end else if (cfg_we) begin
      unique case (tvp_pkg::cfg_idx_t'(cfg_index))
        tvp_pkg::CFG_MAX_SPEED:  cfg_r.max_speed  <= cfg_wdata;
        tvp_pkg::CFG_LOW_SPEED:  cfg_r.low_speed  <= cfg_wdata;
        tvp_pkg::CFG_LOW_MODE:   cfg_r.low_mode   <= cfg_wdata[0];
        tvp_pkg::CFG_RAMP_UP:    cfg_r.ramp_up    <= cfg_wdata;
        tvp_pkg::CFG_RAMP_DOWN:  cfg_r.ramp_down  <= cfg_wdata;
        tvp_pkg::CFG_ACCEL_RATE: cfg_r.accel_rate <= cfg_wdata;
        tvp_pkg::CFG_DECEL_RATE: cfg_r.decel_rate <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Phase decision.
  tvp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .rem       (in_ch.remaining_distance),
    .len       (in_ch.path_length),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  // Root argument.
  tvp_radicand u_radicand (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_speed (cfg_r.max_speed),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (cell_valid[0]),
    .out_ready (cell_ready[0]),
    .out_data  (cell_data[0])
  );

  // Chain of root cells, most significant result bit first.
  for (genvar k = 0; k < tvp_pkg::ROOT_W; k++) begin : g_cell
    tvp_root_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cell_valid[k]),
      .in_ready  (cell_ready[k]),
      .in_data   (cell_data[k]),
      .out_valid (cell_valid[k+1]),
      .out_ready (cell_ready[k+1]),
      .out_data  (cell_data[k+1])
    );
  end

  // Output register: root or fixed speed, as the decode stage chose.
  assign out_stage_ready                = !out_vld_r || out_ch.ready;
  assign cell_ready[tvp_pkg::ROOT_W]    = out_stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_stage_ready) begin
      out_vld_r <= cell_valid[tvp_pkg::ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cell_valid[tvp_pkg::ROOT_W] && out_stage_ready) begin
      speed_r <= cell_data[tvp_pkg::ROOT_W].side.use_root ?
                 cell_data[tvp_pkg::ROOT_W].root :
                 cell_data[tvp_pkg::ROOT_W].side.speed;
      phase_r <= cell_data[tvp_pkg::ROOT_W].side.phase;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.target_speed  = speed_r;
  assign out_ch.profile_phase = phase_r;

endmodule

`default_nettype wire

FILE: rtl/tvp_decode.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner decode stage
// Picks the profile phase and, for the ramps, the rate and ramp distance.
// ----------------------------------------------------------------------------
`default_nettype none

module tvp_decode (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tvp_pkg::tvp_cfg_t          cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tvp_pkg::DIST_W-1:0] rem,
  input  wire logic [tvp_pkg::DIST_W-1:0] len,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tvp_pkg::tvp_dec_t               out_data
);

  logic               vld_r;
  tvp_pkg::tvp_dec_t  dec_r;
  tvp_pkg::tvp_dec_t  dec_nxt;

  logic [tvp_pkg::DSUM_W-1:0] len_x;
  logic [tvp_pkg::DSUM_W-1:0] ramps_sum;
  logic [tvp_pkg::DSUM_W-1:0] up_plus_rem;
  logic                       is_short;
  logic                       is_accel;

  // Travelled is len - rem; the compares are rearranged to stay unsigned.
  // Travelled below ramp_up means len < ramp_up + rem, and travelled below
  // len - ramp_down means rem > ramp_down.
  assign len_x       = {1'b0, len};
  assign ramps_sum   = {1'b0, cfg.ramp_up} + {1'b0, cfg.ramp_down};
  assign up_plus_rem = {1'b0, cfg.ramp_up} + {1'b0, rem};
  assign is_short    = len_x < ramps_sum;
  assign is_accel    = len_x < up_plus_rem;

  // Phase priority chain.
  always_comb begin
    dec_nxt.side.use_root = 1'b0;
    dec_nxt.side.speed    = cfg.low_speed;
    dec_nxt.rate          = cfg.accel_rate;
    dec_nxt.ramp_dist     = up_plus_rem - len_x;
    if (cfg.low_mode) begin
      dec_nxt.side.phase = tvp_pkg::PH_LOW;
    end else if (is_short) begin
      dec_nxt.side.phase = tvp_pkg::PH_SHORT;
    end else if (is_accel) begin
      dec_nxt.side.phase    = tvp_pkg::PH_ACCEL;
      dec_nxt.side.use_root = 1'b1;
    end else if (rem > cfg.ramp_down) begin
      dec_nxt.side.phase = tvp_pkg::PH_CRUISE;
      dec_nxt.side.speed = cfg.max_speed;
    end else if (rem < cfg.ramp_down) begin
      dec_nxt.side.phase    = tvp_pkg::PH_DECEL;
      dec_nxt.side.use_root = 1'b1;
      dec_nxt.rate          = cfg.decel_rate;
      dec_nxt.ramp_dist     = {1'b0, cfg.ramp_down - rem};
    end else begin
      dec_nxt.side.phase = tvp_pkg::PH_ABNORMAL;
    end
  end

  // Stage register; it takes a new item whenever it is empty or draining.
  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dec_r <= dec_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = dec_r;

endmodule

`default_nettype wire

FILE: rtl/tvp_radicand.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner radicand stages
// Forms max_speed^2 - 2*rate*dist over two registered stages, clamped at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tvp_radicand (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tvp_pkg::SPEED_W-1:0] max_speed,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire tvp_pkg::tvp_dec_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tvp_pkg::tvp_root_t               out_data
);

  localparam int DIFF_W = tvp_pkg::PROD_W + 2;

  logic                        prod_vld_r;
  logic                        rad_vld_r;
  logic                        prod_ready;
  logic [tvp_pkg::RAD_W-1:0]   sq_r;
  logic [tvp_pkg::PROD_W-1:0]  prod_r;
  tvp_pkg::tvp_side_t          prod_side_r;
  logic [DIFF_W-1:0]           diff;
  tvp_pkg::tvp_root_t          rad_r;
  tvp_pkg::tvp_root_t          rad_nxt;

  // Handshake: each stage loads when it is empty or its successor drains it.
  assign prod_ready = !rad_vld_r || out_ready;
  assign in_ready   = !prod_vld_r || prod_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      rad_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        prod_vld_r <= in_valid;
      end
      if (prod_ready) begin
        rad_vld_r <= prod_vld_r;
      end
    end
  end

  // Product stage: the square and the rate-distance product side by side.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sq_r        <= max_speed * max_speed;
      prod_r      <= in_data.rate * in_data.ramp_dist;
      prod_side_r <= in_data.side;
    end
  end

  // Radicand stage: subtract twice the product and clamp a negative result.
  assign diff = {{(DIFF_W - tvp_pkg::RAD_W){1'b0}}, sq_r} - {1'b0, prod_r, 1'b0};

  always_comb begin
    rad_nxt.rad  = diff[DIFF_W-1] ? '0 : diff[tvp_pkg::RAD_W-1:0];
    rad_nxt.rem  = '0;
    rad_nxt.root = '0;
    rad_nxt.side = prod_side_r;
  end

  always_ff @(posedge clk) begin
    if (prod_vld_r && prod_ready) begin
      rad_r <= rad_nxt;
    end
  end

  assign out_valid = rad_vld_r;
  assign out_data  = rad_r;

endmodule

`default_nettype wire

FILE: rtl/tvp_root_cell.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner root cell
// One restoring square-root step: brings down two radicand bits and decides
// one root bit, then hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tvp_root_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tvp_pkg::tvp_root_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tvp_pkg::tvp_root_t      out_data
);

  localparam int CUR_W = tvp_pkg::REM_W + 2;

  logic               vld_r;
  tvp_pkg::tvp_root_t word_r;
  tvp_pkg::tvp_root_t word_nxt;
  logic [CUR_W-1:0]   cur;
  logic [CUR_W-1:0]   trial;
  logic [CUR_W-1:0]   diff;
  logic               fits;

  // Partial remainder with the next two radicand bits against 4*root + 1.
  assign cur   = {in_data.rem, in_data.rad[tvp_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, in_data.root, 2'b01};
  assign diff  = cur - trial;
  assign fits  = cur >= trial;

  // The remainder stays within twice the root, so it fits REM_W bits.
  always_comb begin
    word_nxt.rad  = {in_data.rad[tvp_pkg::RAD_W-3:0], 2'b00};
    word_nxt.rem  = fits ? diff[tvp_pkg::REM_W-1:0] : cur[tvp_pkg::REM_W-1:0];
    word_nxt.root = {in_data.root[tvp_pkg::ROOT_W-2:0], fits};
    word_nxt.side = in_data.side;
  end

  // Cell register with the same load rule as every other stage.
  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = word_r;

endmodule

`default_nettype wire

FILE: rtl/tvp_checker.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner checker
// Port-level checks on result ordering, occupancy and phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

module tvp_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [tvp_pkg::PHASE_W-1:0] profile_phase
);

  localparam int OCC_W = $clog2(tvp_pkg::PIPE_DEPTH + 1);

  logic             in_xfer;
  logic             out_xfer;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Items taken in and not yet delivered.
  always_comb begin
    occ_nxt = occ_r;
    if (in_xfer && !out_xfer) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!in_xfer && out_xfer) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // No result without an outstanding item.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("result offered with no item in flight");

  // The pipeline never holds more items than it has stages.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(tvp_pkg::PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  // Only defined phase codes leave the block.
  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> profile_phase <= tvp_pkg::PH_ABNORMAL)
    else $error("undefined profile phase");

  // An item entering an empty block cannot emerge on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && occ_r == '0 |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind trapezoid_velocity_planner_top tvp_checker u_tvp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .profile_phase (out_ch.profile_phase)
);

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner testbench
// Drives distance items into the planner and checks every speed result
// against a predictor of the trapezoidal profile. A directed pass covers
// each phase boundary and the register extremes. Random rounds then reload
// the registers and send mostly well-formed path positions. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 5;
  localparam int MAX_WAIT        = 13;
  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = tvp_pkg::PIPE_DEPTH + 10;
  localparam int RANDOM_ROUNDS   = 8;
  localparam int ITEMS_PER_ROUND = 240;
  localparam int PRINT_LIMIT     = 100;
  localparam logic [tvp_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam logic [tvp_pkg::DIST_W-1:0]    DIST_MAX     = {tvp_pkg::DIST_W{1'b1}};

  // Expected speed and phase for one path position.
  typedef struct {
    logic [tvp_pkg::DIST_W-1:0]  remaining;
    logic [tvp_pkg::DIST_W-1:0]  length;
    logic [tvp_pkg::SPEED_W-1:0] speed;
    tvp_pkg::phase_t             phase;
  } speed_plan_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tvp_pkg::CFG_W-1:0]     cfg_wdata;

  tvp_in_if  in_ch ();
  tvp_out_if out_ch ();

  trapezoid_velocity_planner_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tvp_pkg::tvp_cfg_t cfg_shadow;
  speed_plan_t       plan_q[$];
  int                mismatches  = 0;
  int                idle_cycles = 0;
  int                send_burst  = 0;
  int                stall_burst = 0;

  // Clock generation.
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Builds a register setting.
  function automatic tvp_pkg::tvp_cfg_t make_cfg(
      input logic [tvp_pkg::SPEED_W-1:0] vmax,
      input logic [tvp_pkg::SPEED_W-1:0] vlow,
      input logic mode,
      input logic [tvp_pkg::DIST_W-1:0] up,
      input logic [tvp_pkg::DIST_W-1:0] down,
      input logic [tvp_pkg::RATE_W-1:0] acc,
      input logic [tvp_pkg::RATE_W-1:0] dec);
    tvp_pkg::tvp_cfg_t c;
    c.max_speed  = vmax;
    c.low_speed  = vlow;
    c.low_mode   = mode;
    c.ramp_up    = up;
    c.ramp_down  = down;
    c.accel_rate = acc;
    c.decel_rate = dec;
    return c;
  endfunction

  // Floored square root, settled one result bit at a time from the top.
  function automatic logic [tvp_pkg::SPEED_W-1:0] floor_root(input longint radicand);
    longint root;
    longint trial;
    root = 0;
    for (int b = tvp_pkg::SPEED_W - 1; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root[tvp_pkg::SPEED_W-1:0];
  endfunction

  // Ramp speed: root of vmax^2 - 2*rate*dist, with a negative argument taken as 0.
  function automatic logic [tvp_pkg::SPEED_W-1:0] ramp_speed(
      input logic [tvp_pkg::SPEED_W-1:0] vmax,
      input logic [tvp_pkg::RATE_W-1:0] rate,
      input longint ramp_dist);
    longint arg;
    arg = longint'(vmax) * longint'(vmax) - 2 * longint'(rate) * ramp_dist;
    if (arg < 0) arg = 0;
    return floor_root(arg);
  endfunction

  // Predicts the speed and phase for one position under the given registers.
  function automatic speed_plan_t plan_speed(input tvp_pkg::tvp_cfg_t c,
                                             input logic [tvp_pkg::DIST_W-1:0] remaining,
                                             input logic [tvp_pkg::DIST_W-1:0] length);
    speed_plan_t p;
    longint rem;
    longint len;
    longint up;
    longint down;
    longint trav;
    rem  = longint'(remaining);
    len  = longint'(length);
    up   = longint'(c.ramp_up);
    down = longint'(c.ramp_down);
    trav = len - rem;
    p.remaining = remaining;
    p.length    = length;
    if (c.low_mode) begin
      p.speed = c.low_speed;
      p.phase = tvp_pkg::PH_LOW;
    end else if (len < up + down) begin
      p.speed = c.low_speed;
      p.phase = tvp_pkg::PH_SHORT;
    end else if (trav < up) begin
      p.speed = ramp_speed(c.max_speed, c.accel_rate, up - trav);
      p.phase = tvp_pkg::PH_ACCEL;
    end else if (trav < len - down) begin
      // Travelled exactly equal to the ramp-up distance lands here.
      p.speed = c.max_speed;
      p.phase = tvp_pkg::PH_CRUISE;
    end else if (rem < down) begin
      p.speed = ramp_speed(c.max_speed, c.decel_rate, down - rem);
      p.phase = tvp_pkg::PH_DECEL;
    end else begin
      p.speed = c.low_speed;
      p.phase = tvp_pkg::PH_ABNORMAL;
    end
    return p;
  endfunction

  // Wait before the next item: mostly none, sometimes a random gap,
  // and now and then a long stretch with no idling at all.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      burst = int'($urandom_range(16, 96));
      return 0;
    end
    return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Predict on every input transfer, compare on every result transfer.
  always @(posedge clk) begin : score
    speed_plan_t due;
    if (out_ch.valid && out_ch.ready) begin
      if (plan_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result speed %0d phase %0d",
                                  out_ch.target_speed, out_ch.profile_phase));
      end else begin
        due = plan_q.pop_front();
        if (out_ch.target_speed !== due.speed)
          report_mismatch($sformatf("rem %0d len %0d: speed %0d, expected %0d",
                                    due.remaining, due.length,
                                    out_ch.target_speed, due.speed));
        if (out_ch.profile_phase !== due.phase)
          report_mismatch($sformatf("rem %0d len %0d: phase %0d, expected %s",
                                    due.remaining, due.length,
                                    out_ch.profile_phase, due.phase.name()));
      end
    end
    if (in_ch.valid && in_ch.ready)
      plan_q.push_back(plan_speed(cfg_shadow, in_ch.remaining_distance,
                                  in_ch.path_length));
  end

  // Ends the run when neither channel nor the register port moves for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: stall at random before accepting each result.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(stall_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Sends one position; returns on the edge of its transfer.
  task automatic send_item(input logic [tvp_pkg::DIST_W-1:0] remaining,
                           input logic [tvp_pkg::DIST_W-1:0] length);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.remaining_distance <= remaining;
    in_ch.path_length        <= length;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds the sender until every expected result has come and the pipe is empty.
  // One edge passes first so that the last transfer is already in the queue.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (plan_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after the last one.
  task automatic write_reg(input logic [tvp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tvp_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      tvp_pkg::CFG_MAX_SPEED:  cfg_shadow.max_speed  = data;
      tvp_pkg::CFG_LOW_SPEED:  cfg_shadow.low_speed  = data;
      tvp_pkg::CFG_LOW_MODE:   cfg_shadow.low_mode   = data[0];
      tvp_pkg::CFG_RAMP_UP:    cfg_shadow.ramp_up    = data;
      tvp_pkg::CFG_RAMP_DOWN:  cfg_shadow.ramp_down  = data;
      tvp_pkg::CFG_ACCEL_RATE: cfg_shadow.accel_rate = data;
      tvp_pkg::CFG_DECEL_RATE: cfg_shadow.decel_rate = data;
      default: ;
    endcase
  endtask

  // Loads every register; the mode bit carries random upper bits, and a
  // write to the unmapped index follows, which must change nothing.
  task automatic load_config(input tvp_pkg::tvp_cfg_t c);
    write_reg(tvp_pkg::CFG_MAX_SPEED,  c.max_speed);
    write_reg(tvp_pkg::CFG_LOW_SPEED,  c.low_speed);
    write_reg(tvp_pkg::CFG_LOW_MODE,   {15'($urandom), c.low_mode});
    write_reg(tvp_pkg::CFG_RAMP_UP,    c.ramp_up);
    write_reg(tvp_pkg::CFG_RAMP_DOWN,  c.ramp_down);
    write_reg(tvp_pkg::CFG_ACCEL_RATE, c.accel_rate);
    write_reg(tvp_pkg::CFG_DECEL_RATE, c.decel_rate);
    write_reg(CFG_UNMAPPED,            16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Random register setting; most kinds keep both ramps inside a path.
  function automatic tvp_pkg::tvp_cfg_t pick_profile(input int kind);
    tvp_pkg::tvp_cfg_t c;
    longint reach;
    c = make_cfg(16'($urandom), 16'($urandom), 1'b0, '0, '0,
                 16'($urandom), 16'($urandom));
    case (kind % 4)
      0: begin
        c.ramp_up   = 16'($urandom_range(0, 255));
        c.ramp_down = 16'($urandom_range(0, 255));
      end
      1: begin
        // Rates matched to the ramps so that the roots sweep their full range.
        c.ramp_up   = 16'($urandom_range(1, 16383));
        c.ramp_down = 16'($urandom_range(1, 16383));
        reach = longint'(c.max_speed) * longint'(c.max_speed) / (2 * longint'(c.ramp_up));
        c.accel_rate = (reach > 65535) ? 16'hFFFF : 16'(reach);
        reach = longint'(c.max_speed) * longint'(c.max_speed) / (2 * longint'(c.ramp_down));
        c.decel_rate = (reach > 65535) ? 16'hFFFF : 16'(reach);
      end
      2: begin
        c.ramp_up   = 16'($urandom_range(0, 32767));
        c.ramp_down = 16'($urandom_range(0, 32767));
      end
      default: begin
        c.low_mode  = 1'($urandom_range(0, 1));
        c.ramp_up   = 16'($urandom);
        c.ramp_down = 16'($urandom);
      end
    endcase
    return c;
  endfunction

  // Random position: mostly on the path, biased to the ramps and the
  // phase boundaries, with some beyond the path and some pure noise.
  task automatic send_random_item();
    logic [tvp_pkg::DIST_W-1:0] rem;
    logic [tvp_pkg::DIST_W-1:0] len;
    longint up;
    longint down;
    longint span;
    int pick;
    up   = longint'(cfg_shadow.ramp_up);
    down = longint'(cfg_shadow.ramp_down);
    span = (up + down > 65535) ? 65535 : up + down;
    len  = tvp_pkg::DIST_W'($urandom_range(65535, int'(span)));
    pick = int'($urandom_range(0, 99));
    if (pick < 10) begin
      rem = tvp_pkg::DIST_W'($urandom);
      len = tvp_pkg::DIST_W'($urandom);
    end else if (pick < 18) begin
      rem = tvp_pkg::DIST_W'($urandom_range(65535, int'(len)));
    end else if (pick < 30) begin
      case ($urandom_range(0, 5))
        0: rem = tvp_pkg::DIST_W'(down);
        1: rem = tvp_pkg::DIST_W'(down - 1);
        2: rem = tvp_pkg::DIST_W'(down + 1);
        3: rem = tvp_pkg::DIST_W'(longint'(len) - up);
        4: rem = tvp_pkg::DIST_W'(longint'(len) - up - 1);
        default: rem = tvp_pkg::DIST_W'(longint'(len) - up + 1);
      endcase
    end else if (pick < 50) begin
      rem = tvp_pkg::DIST_W'($urandom_range(0, (down < len) ? int'(down) : int'(len)));
    end else if (pick < 70) begin
      rem = tvp_pkg::DIST_W'(longint'(len) - longint'($urandom_range(0, int'(up))));
    end else begin
      rem = tvp_pkg::DIST_W'($urandom_range(0, int'(len)));
    end
    send_item(rem, len);
  endtask

  // Reset defaults: each phase but low mode, with its boundaries, mostly on a 1000-long path.
  task automatic test_reset_profile();
    send_item(16'd100, 16'd299);          // one short of both ramps
    send_item(16'd0, 16'd300);            // ramps exactly fill the path
    send_item(16'd1000, 16'd1000);        // start of path, root argument exactly 0
    send_item(16'd900, 16'd1000);         // inside acceleration
    send_item(16'd851, 16'd1000);         // last step of acceleration
    send_item(16'd850, 16'd1000);         // travelled equals ramp-up: cruise
    send_item(16'd151, 16'd1000);         // last cruise position
    send_item(16'd150, 16'd1000);         // remaining equals ramp-down: abnormal
    send_item(16'd149, 16'd1000);         // first deceleration step
    send_item(16'd0, 16'd1000);           // end of path
    send_item(16'd1050, 16'd1000);        // beyond the path, negative argument
    send_item(16'd2000, 16'd1000);
    send_item(DIST_MAX, DIST_MAX);
    send_item(16'd0, 16'd0);
    send_item(16'd0, DIST_MAX);
    send_item(DIST_MAX, 16'd0);
    drain_results();
  endtask

  // Register extremes, a few positions each.
  task automatic test_register_extremes();
    load_config(make_cfg(16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_item(16'd0, 16'd0);
    send_item(16'd1, 16'd0);
    send_item(16'd5, DIST_MAX);
    drain_results();
    load_config(make_cfg(16'hFFFF, 16'd0, 1'b0, 16'd32767, 16'd32767,
                         16'hFFFF, 16'hFFFF));
    send_item(16'd32767, 16'd65534);
    send_item(16'd0, DIST_MAX);
    send_item(DIST_MAX, DIST_MAX);
    drain_results();
    load_config(make_cfg(16'd1, 16'd7, 1'b0, DIST_MAX, DIST_MAX, 16'd1, 16'd1));
    send_item(DIST_MAX, DIST_MAX);
    drain_results();
    load_config(make_cfg(16'd480, 16'd0, 1'b1, 16'd150, 16'd150, 16'd768, 16'd768));
    send_item(DIST_MAX, DIST_MAX);
    send_item(16'd500, 16'd1000);
    drain_results();
    load_config(make_cfg(16'd0, 16'd1, 1'b0, 16'd10, 16'd10, 16'hFFFF, 16'hFFFF));
    send_item(16'd5, 16'd100);
    send_item(16'd100, 16'd100);
    drain_results();
  endtask

  // Random rounds, each under a fresh register setting, with one mid-round
  // pause until all outstanding results have come back.
  task automatic test_random_profiles();
    int pause_at;
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      load_config(pick_profile(r));
      pause_at = int'($urandom_range(20, ITEMS_PER_ROUND - 20));
      for (int i = 0; i < ITEMS_PER_ROUND; i++) begin
        if (i == pause_at) drain_results();
        send_random_item();
      end
      drain_results();
    end
  endtask

  // Test sequence.
  initial begin
    cfg_shadow               = make_cfg(16'd480, 16'd200, 1'b0, 16'd150, 16'd150,
                                        16'd768, 16'd768);
    rst_n                    <= 1'b0;
    in_ch.valid              <= 1'b0;
    in_ch.remaining_distance <= '0;
    in_ch.path_length        <= '0;
    cfg_we                   <= 1'b0;
    cfg_index                <= tvp_pkg::CFG_MAX_SPEED;
    cfg_wdata                <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_profile();
    test_register_extremes();
    test_random_profiles();
    drain_results();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: trapezoid_velocity_planner_top.f
rtl/tvp_pkg.sv
rtl/tvp_ifs.sv
rtl/tvp_decode.sv
rtl/tvp_radicand.sv
rtl/tvp_root_cell.sv
rtl/trapezoid_velocity_planner_top.sv
rtl/tvp_checker.sv
dv/tb.sv
